>>> sv/pixel_color_effects_unit_assert.svh
// Assertion macros shared by the pixel colour effects modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PIXEL_COLOR_EFFECTS_UNIT_ASSERT_SVH
`define PIXEL_COLOR_EFFECTS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pce_pkg.sv
`default_nettype none

package pce_pkg;

    localparam int QueueDepth = 4;

    localparam int CfgIdxW = 8;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegSepia   = 8'd0;
    localparam logic [CfgIdxW-1:0] RegGray    = 8'd1;
    localparam logic [CfgIdxW-1:0] RegCartoon = 8'd2;
    localparam logic [CfgIdxW-1:0] RegInvert  = 8'd3;

    localparam int CoefW  = 10;
    localparam int ChanW  = 8;
    localparam int PartW  = CoefW + ChanW;
    localparam int SumW   = PartW + 1;
    localparam int RecipW = 20;
    localparam int ProdW  = SumW + RecipW;
    localparam int QuotW  = 10;

    // floor(x / 1000) equals (x * Recip1000) >> RecipShift for every x below 2^19.
    localparam logic [RecipW-1:0] Recip1000 = 20'd536871;
    localparam int RecipShift = 29;

    // Sepia matrix in thousandths, row per output channel (red, green, blue).
    localparam logic [CoefW-1:0] SepiaCoef [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    localparam logic [CoefW-1:0] GrayCoef [3] = '{10'd210, 10'd710, 10'd71};

    typedef struct packed {
        logic sepia;
        logic gray;
        logic cartoon;
        logic invert;
    } fx_flags_t;

    // One queued word: the effects chosen for the pixel and the pixel itself.
    typedef struct packed {
        fx_flags_t   fx;
        logic [31:0] pixel;
    } pce_entry_t;

    // Side data carried down the back pipeline; channel 0 is red.
    typedef struct packed {
        fx_flags_t             fx;
        logic [ChanW-1:0]      alpha;
        logic [2:0][ChanW-1:0] ch;
    } pce_meta_t;

    function automatic logic [ChanW-1:0] sat255(input logic [QuotW-1:0] v);
        return (v > 10'd255) ? 8'd255 : v[ChanW-1:0];
    endfunction

    function automatic logic [ChanW-1:0] quantize(input logic [ChanW-1:0] v);
        logic [ChanW-1:0] r;
        case (v) inside
            [8'd0:8'd49]:    r = 8'd25;
            [8'd50:8'd99]:   r = 8'd75;
            [8'd100:8'd199]: r = 8'd150;
            [8'd200:8'd249]: r = 8'd225;
            default:         r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/pce_front.sv
`default_nettype none

module pce_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pce_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic                        cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [31:0]                 pixel_in,
    input  wire logic                        q_full,
    output logic                             q_push,
    output pce_pkg::pce_entry_t              q_entry
);
    import pce_pkg::*;

    fx_flags_t fx_reg;

    // Writes always taken; the user, unchecked, writes only to an idle block.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegSepia:   fx_reg.sepia   <= cfg_data;
                RegGray:    fx_reg.gray    <= cfg_data;
                RegCartoon: fx_reg.cartoon <= cfg_data;
                RegInvert:  fx_reg.invert  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Each accepted pixel is tagged with the effects in force when it arrived.
    assign full          = q_full;
    assign q_push        = push && !q_full;
    assign q_entry.fx    = fx_reg;
    assign q_entry.pixel = pixel_in;

endmodule

`default_nettype wire

>>> sv/pce_fifo.sv
`default_nettype none
`include "pixel_color_effects_unit_assert.svh"

module pce_fifo #(
    parameter int DEPTH = pce_pkg::QueueDepth
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire pce_pkg::pce_entry_t wr_data,
    output logic                     full,
    input  wire logic                rd_en,
    output pce_pkg::pce_entry_t      rd_data,
    output logic                     empty
);
    import pce_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    pce_entry_t            mem_reg [DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg;
    logic [PtrW-1:0]       rd_ptr_reg;
    logic [CntW-1:0]       count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `PCE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CntW'(DEPTH), "queue count above depth")
    `PCE_ASSERT_IMP(a_empty_ptrs, empty, rd_ptr_reg == wr_ptr_reg, "empty queue with split pointers")
    `PCE_ASSERT_NXT(a_read_only, do_rd && !do_wr, count_reg == $past(count_reg) - CntW'(1),
        "queue count not reduced by a lone read")

endmodule

`default_nettype wire

>>> sv/pce_back.sv
`default_nettype none
`include "pixel_color_effects_unit_assert.svh"

module pce_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire pce_pkg::pce_entry_t q_entry,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output logic [31:0]              pixel_out
);
    import pce_pkg::*;

    logic [7:1]            vld_reg;
    logic                  advance;

    pce_meta_t             meta_in;
    pce_meta_t             m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic [PartW-1:0]      p1_reg [3][3];
    logic [SumW-1:0]       s2_reg [3];
    logic [QuotW-1:0]      q3_reg [3];
    logic [PartW-1:0]      gp4_reg [3];
    logic [SumW-1:0]       gs5_reg;
    logic [QuotW-1:0]      gq6_reg;
    logic [31:0]           out_reg;

    logic [ProdW-1:0]      prod3 [3];
    logic [ProdW-1:0]      gprod6;
    logic [2:0][ChanW-1:0] sep_ch;
    logic [2:0][ChanW-1:0] fin_ch;
    logic [ChanW-1:0]      gray_val;

    // The whole pipeline moves together; it holds only when a finished word waits.
    assign advance = !vld_reg[7] || pop;
    assign q_pop   = advance && !q_empty;
    assign empty   = !vld_reg[7];

    assign meta_in.fx    = q_entry.fx;
    assign meta_in.alpha = q_entry.pixel[31:24];
    assign meta_in.ch[0] = q_entry.pixel[23:16];
    assign meta_in.ch[1] = q_entry.pixel[15:8];
    assign meta_in.ch[2] = q_entry.pixel[7:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod3[k]  = ProdW'(s2_reg[k]) * ProdW'(Recip1000);
            sep_ch[k] = m3_reg.fx.sepia ? sat255(q3_reg[k]) : m3_reg.ch[k];
        end
    end

    always_comb
    begin
        gprod6   = ProdW'(gs5_reg) * ProdW'(Recip1000);
        gray_val = sat255(gq6_reg);
        for (int k = 0; k < 3; k++)
        begin
            fin_ch[k] = m6_reg.fx.gray ? gray_val : m6_reg.ch[k];
            if (m6_reg.fx.cartoon)
            begin
                fin_ch[k] = quantize(fin_ch[k]);
            end
            if (m6_reg.fx.invert)
            begin
                fin_ch[k] = ~fin_ch[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[6:1], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Sepia: products, sums, then division by a thousand.
            m1_reg <= meta_in;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p1_reg[k][j] <= PartW'(SepiaCoef[k][j]) * PartW'(meta_in.ch[j]);
                end
            end
            m2_reg <= m1_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_reg[k] <= SumW'(p1_reg[k][0]) + SumW'(p1_reg[k][1]) + SumW'(p1_reg[k][2]);
            end
            m3_reg <= m2_reg;
            for (int k = 0; k < 3; k++)
            begin
                q3_reg[k] <= prod3[k][RecipShift+QuotW-1:RecipShift];
            end
            // Grayscale works on the sepia result.
            m4_reg.fx    <= m3_reg.fx;
            m4_reg.alpha <= m3_reg.alpha;
            m4_reg.ch    <= sep_ch;
            for (int k = 0; k < 3; k++)
            begin
                gp4_reg[k] <= PartW'(GrayCoef[k]) * PartW'(sep_ch[k]);
            end
            m5_reg  <= m4_reg;
            gs5_reg <= SumW'(gp4_reg[0]) + SumW'(gp4_reg[1]) + SumW'(gp4_reg[2]);
            m6_reg  <= m5_reg;
            gq6_reg <= gprod6[RecipShift+QuotW-1:RecipShift];
            out_reg <= {m6_reg.alpha, fin_ch[0], fin_ch[1], fin_ch[2]};
        end
    end

    assign pixel_out = out_reg;

    `PCE_ASSERT_NXT(a_result_kept, vld_reg[7] && !pop, vld_reg[7], "waiting result dropped")
    `PCE_ASSERT_NXT(a_result_stable, vld_reg[7] && !pop, $stable(pixel_out),
        "waiting result changed")
    `PCE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "queue read while empty")

endmodule

`default_nettype wire

>>> sv/pixel_color_effects_unit.sv
// Pixel colour effects unit: sepia, grayscale, cartoon and inversion on ARGB pixels.
// Throughput: one pixel per clock while pop is held high; no dependence between pixels.
// An accepted pixel is written into the queue, then passes through the seven stages
// of the back pipeline (two divisions) before it shows on pixel_out.
// Reset: rst_n is asynchronous, active low; it clears the enables, the queue and the
// stage valid bits, so the block comes out of reset empty and with all effects off.
`default_nettype none

module pixel_color_effects_unit #(
    parameter int QUEUE_DEPTH = pce_pkg::QueueDepth
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pce_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic                        cfg_data,
    // Input side: a word is taken when push is high and full is low.
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [31:0]                 pixel_in,
    // Result side: a word is taken when pop is high and empty is low.
    output logic                             empty,
    input  wire logic                        pop,
    output logic [31:0]                      pixel_out
);
    import pce_pkg::*;

    // The front end holds the effect enables and tags each incoming word with
    // them, so the back end never needs to look at the configuration itself.
    pce_entry_t wr_entry;
    pce_entry_t rd_entry;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;

    pce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    // A short queue separates the two halves: the front can keep taking words
    // while the back end is held by a result that has not yet been popped.
    pce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_entry),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_entry),
        .empty   (q_empty)
    );

    // The back end is a seven-stage pipeline: sepia products, sums and a
    // divide by a thousand via a constant reciprocal; then the same for the
    // grayscale weights; the last stage quantises, inverts and registers the
    // result word, which waits on pixel_out until it is popped.
    pce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

endmodule

`default_nettype wire

>>> verif/pixel_color_effects_unit_test.sv
`default_nettype none

// Bench for the pixel colour effects unit.
//
// A queue-like handshake sits on each side of the block: pixels go in with
// push/full and filtered pixels come out with empty/pop. Every accepted pixel
// gives exactly one filtered pixel, in order, so the bench keeps a FIFO of
// filtered pixels predicted from its own copy of the four effect enables.
// The result process compares each popped word against the oldest entry.
//
// The effect enables are only rewritten once the block has been drained. The
// random part walks through all sixteen enable combinations, so both
// extremes (nothing enabled, everything enabled) are covered. Writes to
// register indexes beyond the last enable are mixed in and must be ignored.
module pixel_color_effects_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on any channel before the run is abandoned.
    // The slowest legal stretch is a random sender or receiver gap plus the
    // seven-stage pipeline, so this leaves a wide margin.
    localparam int WatchdogLimit = 2000;
    // Quiet cycles after the last result, to catch stray words from the block.
    localparam int EndSettleCycles = 16;
    // Pixels per enable combination in the random part.
    localparam int PixelsPerSetting = 27;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [pce_pkg::CfgIdxW-1:0] cfg_index;
    logic                        cfg_data;
    logic                        push;
    logic                        full;
    logic [31:0]                 pixel_in;
    logic                        empty;
    logic                        pop;
    logic [31:0]                 pixel_out;

    // The bench's own copy of the enables, updated at each accepted write.
    pce_pkg::fx_flags_t effects;
    // Filtered pixels still to come out of the block, oldest first.
    logic [31:0]        filtered_pixels [$];

    // Idling switches for the two sides; each test sets them for its phase.
    bit send_idling;
    bit pop_idling;

    int pixels_sent;
    int pixels_checked;
    int mismatch_count;
    int ignored_writes;
    int settings_seen;
    int quiet_cycles;

    pixel_color_effects_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamps an intermediate channel value to the byte range.
    function automatic int unsigned clamp_byte(input int unsigned v);
        return (v > 255) ? 255 : v;
    endfunction

    // Works out the filtered pixel for the current enables. The effects are
    // applied in the block's fixed order, each to the previous result, and all
    // divisions by 1000 truncate. Alpha is carried across untouched.
    function automatic logic [31:0] filter_pixel(input logic [31:0] px);
        int unsigned ch [3];
        int unsigned mixed [3];
        int unsigned luma;
        int k;
        ch[0] = px[23:16];
        ch[1] = px[15:8];
        ch[2] = px[7:0];
        if (effects.sepia)
        begin
            mixed[0] = clamp_byte((393 * ch[0] + 769 * ch[1] + 189 * ch[2]) / 1000);
            mixed[1] = clamp_byte((349 * ch[0] + 686 * ch[1] + 168 * ch[2]) / 1000);
            mixed[2] = clamp_byte((272 * ch[0] + 534 * ch[1] + 131 * ch[2]) / 1000);
            ch = mixed;
        end
        if (effects.gray)
        begin
            luma = clamp_byte((210 * ch[0] + 710 * ch[1] + 71 * ch[2]) / 1000);
            ch[0] = luma;
            ch[1] = luma;
            ch[2] = luma;
        end
        if (effects.cartoon)
        begin
            // Four-level posterisation; the top band passes through as it is.
            for (k = 0; k < 3; k++)
            begin
                if (ch[k] < 50)
                    ch[k] = 25;
                else if (ch[k] < 100)
                    ch[k] = 75;
                else if (ch[k] < 200)
                    ch[k] = 150;
                else if (ch[k] < 250)
                    ch[k] = 225;
            end
        end
        if (effects.invert)
        begin
            for (k = 0; k < 3; k++)
                ch[k] = 255 - ch[k];
        end
        return {px[31:24], ch[0][7:0], ch[1][7:0], ch[2][7:0]};
    endfunction

    // A random pixel in which each colour channel now and then lands on a fixed
    // value: a posterisation band boundary, a byte extreme, 128 or 254.
    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        int k;
        px = $urandom;
        for (k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 11))
                    0:       px[8*k +: 8] = 8'd0;
                    1:       px[8*k +: 8] = 8'd49;
                    2:       px[8*k +: 8] = 8'd50;
                    3:       px[8*k +: 8] = 8'd99;
                    4:       px[8*k +: 8] = 8'd100;
                    5:       px[8*k +: 8] = 8'd199;
                    6:       px[8*k +: 8] = 8'd200;
                    7:       px[8*k +: 8] = 8'd249;
                    8:       px[8*k +: 8] = 8'd250;
                    9:       px[8*k +: 8] = 8'd254;
                    10:      px[8*k +: 8] = 8'd128;
                    default: px[8*k +: 8] = 8'd255;
                endcase
            end
        end
        return px;
    endfunction

    // Sends one pixel. push is left high on return so that a following pixel
    // with no gap goes in on the very next edge; a gap lowers it first.
    task automatic send_pixel(input logic [31:0] px);
        int gap;
        gap = send_idling ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (full)
            @(posedge clk);
        filtered_pixels.push_back(filter_pixel(px));
        pixels_sent++;
    endtask

    // Stops sending and waits until every predicted pixel has come back.
    // The task always waits for a clock edge first, so push is never assigned
    // twice in the same time step.
    task automatic drain_pipeline();
        push <= 1'b0;
        @(posedge clk);
        while (filtered_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register. cfg_valid stays high on return; the caller lowers
    // it after the last write of a series.
    task automatic write_reg(input logic [pce_pkg::CfgIdxW-1:0] index, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            pce_pkg::RegSepia:   effects.sepia   = value;
            pce_pkg::RegGray:    effects.gray    = value;
            pce_pkg::RegCartoon: effects.cartoon = value;
            pce_pkg::RegInvert:  effects.invert  = value;
            default:             ignored_writes++;
        endcase
    endtask

    // Drains the block and loads all four enables from a mask, sepia enable
    // in bit 0. Now and then a write to an unused index is slipped in.
    task automatic apply_settings(input logic [3:0] mask);
        drain_pipeline();
        write_reg(pce_pkg::RegSepia, mask[0]);
        if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(pce_pkg::RegInvert + 1, 255)), 1'($urandom));
        write_reg(pce_pkg::RegGray, mask[1]);
        write_reg(pce_pkg::RegCartoon, mask[2]);
        write_reg(pce_pkg::RegInvert, mask[3]);
        cfg_valid <= 1'b0;
        settings_seen++;
    endtask

    // Straight out of reset every effect is off, so pixels must pass through.
    task automatic test_passthrough_after_reset();
        send_idling = 1'b0;
        pop_idling  = 1'b0;
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA512_3456);
    endtask

    // Each effect on its own, on values that reach its corner cases.
    task automatic test_single_effects();
        send_idling = 1'b1;
        pop_idling  = 1'b1;
        // Sepia saturates on a white pixel and truncates on a dark one.
        apply_settings(4'b0001);
        send_pixel(32'h80FF_FFFF);
        send_pixel(32'h7F10_2030);
        // Grayscale of full white stays just below the top of the range.
        apply_settings(4'b0010);
        send_pixel(32'h01FF_FFFF);
        send_pixel(32'hFE64_96C8);
        // Posterisation either side of every band boundary.
        apply_settings(4'b0100);
        send_pixel(32'h0031_3263);
        send_pixel(32'h3364_C7C8);
        send_pixel(32'hCCF9_FAFF);
        // Inversion of mid values and of a pure alpha word.
        apply_settings(4'b1000);
        send_pixel(32'h1234_5678);
        send_pixel(32'hFF00_0000);
    endtask

    // The whole chain at once, on the two extremes of the colour range and a mid grey.
    task automatic test_all_effects();
        send_idling = 1'b0;
        pop_idling  = 1'b1;
        apply_settings(4'b1111);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0080_8080);
        send_pixel(32'h5A00_0000);
    endtask

    // Writes of one to indexes past the last enable must change nothing. The
    // indexes are chosen so that a decoder looking only at the low bits would
    // switch an effect on.
    task automatic test_unused_registers();
        send_idling = 1'b1;
        pop_idling  = 1'b0;
        apply_settings(4'b0000);
        // The write channel idles before the next series.
        @(posedge clk);
        write_reg(pce_pkg::RegInvert + 8'd1, 1'b1);
        write_reg(pce_pkg::RegInvert + 8'd2, 1'b1);
        write_reg(pce_pkg::RegInvert + 8'd3, 1'b1);
        write_reg(pce_pkg::RegInvert + 8'd4, 1'b1);
        write_reg(8'hFF, 1'b1);
        cfg_valid <= 1'b0;
        send_pixel(32'h3C6E_A0D2);
        send_pixel(32'hC301_FE7F);
    endtask

    // Random pixels under every enable combination. Each phase picks its own
    // idling for both sides, so some phases run flat out, and once per phase
    // the sender holds off until the block has emptied.
    task automatic test_random_settings();
        int combo;
        int n;
        int hold_at;
        for (combo = 0; combo < 16; combo++)
        begin
            apply_settings(4'(combo));
            send_idling = ($urandom_range(0, 3) != 0);
            pop_idling  = ($urandom_range(0, 3) != 0);
            hold_at     = $urandom_range(3, PixelsPerSetting - 3);
            for (n = 0; n < PixelsPerSetting; n++)
            begin
                if (n == hold_at)
                    drain_pipeline();
                send_pixel(random_pixel());
            end
        end
    endtask

    // Result side: with pop_idling set, waits a random gap before each word,
    // then holds pop until a word is taken and checks it against the oldest
    // predicted pixel.
    initial
    begin
        int gap;
        logic [31:0] wanted;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pop_idling ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (filtered_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: pixel_out with nothing pending: expected none, actual %h",
                         $time, pixel_out);
            end
            else
            begin
                wanted = filtered_pixels.pop_front();
                pixels_checked++;
                if (pixel_out !== wanted)
                begin
                    mismatch_count++;
                    $display("%0t: pixel_out mismatch: expected %h, actual %h",
                             $time, wanted, pixel_out);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("%0t: no word moved for %0d cycles, %0d pixels still pending",
                     $time, quiet_cycles, filtered_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence: reset, the directed tests, the random sweep, then the
    // final drain and verdict.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= 1'b0;
        push      <= 1'b0;
        pixel_in  <= '0;
        effects   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_after_reset();
        test_single_effects();
        test_all_effects();
        test_unused_registers();
        test_random_settings();

        drain_pipeline();
        repeat (EndSettleCycles) @(posedge clk);

        $display("Filtered %0d pixels and checked %0d of them across %0d effect settings.",
                 pixels_sent, pixels_checked, settings_seen);
        $display("All sixteen enable combinations were swept; %0d writes hit unused indexes.",
                 ignored_writes);
        if (mismatch_count == 0 && filtered_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/pce_pkg.sv
sv/pce_front.sv
sv/pce_fifo.sv
sv/pce_back.sv
sv/pixel_color_effects_unit.sv
verif/pixel_color_effects_unit_test.sv
